// ===== rtl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants for one LRU cache set
// Way count, tag width, age width and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

	localparam int WAYS         = 4;
	localparam int TAG_BITS     = 32;
	localparam int TAG_IN_BITS  = 32;
	localparam int WAY_OUT_BITS = 2;
	localparam int WAY_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AGE_BITS     = $clog2(WAYS + 1);

	typedef logic [WAY_BITS-1:0]     way_idx_t;
	typedef logic [AGE_BITS-1:0]     age_t;
	typedef logic [TAG_BITS-1:0]     tag_t;
	typedef logic [WAY_OUT_BITS-1:0] way_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_FILL   = 1'b1;

	// Command from the sequencer to the age/valid bank
	typedef struct packed {
		logic     refresh;
		logic     set_valid;
		way_idx_t way;
	} age_cmd_t;

	// Reduce a way index to the width of the result port
	function automatic way_out_t way_to_out(way_idx_t w);
		logic [31:0] wide;
		wide = 32'(w);
		return wide[WAY_OUT_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/salc_age.sv =====
// ----------------------------------------------------------------------------
// salc_age: valid bits and LRU age counters of one set
// Refresh lowers every age above the refreshed way's age, then sets it to WAYS.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_age
	import salc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire age_cmd_t   cmd,
	output logic [WAYS-1:0] valid_ways,
	output age_t            ages [WAYS]
);

	logic [WAYS-1:0] valid_q;
	age_t            age_q [WAYS];
	age_t            ref_age;

	assign ref_age = age_q[cmd.way];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < WAYS; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (cmd.set_valid) begin
				valid_q[cmd.way] <= 1'b1;
			end
			if (cmd.refresh) begin
				for (int i = 0; i < WAYS; i++) begin
					if (way_idx_t'(i) == cmd.way) begin
						age_q[i] <= age_t'(WAYS);
					end else if (age_q[i] > ref_age) begin
						age_q[i] <= age_q[i] - age_t'(1);
					end
				end
			end
		end
	end

	assign valid_ways = valid_q;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			ages[i] = age_q[i];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_lru_cache_set_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_set_top: one set of a set-associative cache, LRU ages
// Lookup or fill one tag per transaction with a way-serial scan.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with func and tag while busy is low; the transaction is
//   taken at that clock edge. func = 0 looks the tag up among the valid
//   ways, func = 1 installs the tag in the least recently used way.
//   The result comes back on hit and way, marked by done for exactly one
//   cycle. A lookup miss returns hit = 0, way = 0; a fill returns hit = 0
//   and the replaced way.
// Timing:
//   A tag comparator and an age comparator walk the ways, one per cycle,
//   followed by an update state that updates tag, valid bit and ages. A
//   lookup that hits stops the walk at the matching way. busy drops in
//   the cycle done is high, so the next transaction can be taken at the
//   edge that ends that cycle.
// Reset:
//   arst_n clears valid bits, ages and the sequencer; stored tags are
//   only compared once their way is valid. The receiver cannot stall:
//   each result is flagged by done only once.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_set_top
	import salc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    func,
	input  wire logic [TAG_IN_BITS-1:0]  tag,
	output logic                         done,
	output logic                         hit,
	output logic [WAY_OUT_BITS-1:0]      way
);

	state_t   state_q, state_nxt;

	// Transaction registers
	logic     func_q;
	tag_t     tag_q;
	way_idx_t idx_q;
	way_idx_t sel_q;
	age_t     best_q;
	logic     found_q;

	// Result registers
	logic     done_q;
	logic     hit_q;
	way_out_t way_q;

	// Tag store; entries are meaningful only while their way is valid
	tag_t     tag_mem_q [WAYS];

	logic [WAYS-1:0] valid_ways;
	age_t            ages [WAYS];
	age_cmd_t        age_cmd;

	logic     accept;
	logic     last_idx;
	logic     tag_match;
	logic     age_less;
	logic     scan_en;
	logic     upd_en;

	assign accept    = start && (state_q == ST_IDLE);
	assign last_idx  = (idx_q == way_idx_t'(WAYS - 1));

	// Compare logic on the current way: tag equality for lookups, age order for fills
	assign tag_match = valid_ways[idx_q] && (tag_mem_q[idx_q] == tag_q);
	assign age_less  = (idx_q == '0) || (ages[idx_q] < best_q);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_idx || (func_q == FUNC_LOOKUP && tag_match)) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		scan_en = 1'b0;
		upd_en  = 1'b0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE:   busy    = 1'b0;
			ST_SCAN:   scan_en = 1'b1;
			ST_UPDATE: upd_en  = 1'b1;
			default:   busy    = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= upd_en;
		end
	end

	// Capture the transaction and walk the ways
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			tag_q   <= tag[TAG_BITS-1:0];
			idx_q   <= '0;
			sel_q   <= '0;
			best_q  <= '0;
			found_q <= 1'b0;
		end else if (scan_en) begin
			if (func_q == FUNC_LOOKUP) begin
				if (tag_match) begin
					found_q <= 1'b1;
					sel_q   <= idx_q;
				end
			end else if (age_less) begin
				best_q <= ages[idx_q];
				sel_q  <= idx_q;
			end
			if (!last_idx) begin
				idx_q <= idx_q + way_idx_t'(1);
			end
		end
	end

	// Install the tag on a fill
	always_ff @(posedge clk) begin
		if (upd_en && func_q == FUNC_FILL) begin
			tag_mem_q[sel_q] <= tag_q;
		end
	end

	// Drive the age bank: refresh on hit or fill, mark valid on fill
	always_comb begin
		age_cmd.way       = sel_q;
		age_cmd.set_valid = upd_en && (func_q == FUNC_FILL);
		age_cmd.refresh   = upd_en && (found_q || func_q == FUNC_FILL);
	end

	salc_age u_age (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (age_cmd),
		.valid_ways (valid_ways),
		.ages       (ages)
	);

	// Register the result that done flags for one cycle; miss reports way 0
	always_ff @(posedge clk) begin
		if (upd_en) begin
			hit_q <= (func_q == FUNC_LOOKUP) && found_q;
			if (func_q == FUNC_FILL || found_q) begin
				way_q <= way_to_out(sel_q);
			end else begin
				way_q <= '0;
			end
		end
	end

	assign done = done_q;
	assign hit  = hit_q;
	assign way  = way_q;

endmodule

`default_nettype wire

// ===== sim/set_assoc_lru_cache_set_top_test.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_set_top_test: self-checking bench for one LRU cache set
// Drives lookup and fill transactions through the start/busy handshake,
// tracks tags, valid bits and LRU ages alongside the block, and checks every
// done strobe against the outcome predicted at acceptance.
// ----------------------------------------------------------------------------

module set_assoc_lru_cache_set_top_test;
	import salc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Idle cycles allowed with no transaction taken and no result seen
	localparam int STALL_LIMIT = 4000;
	// Quiet cycles after the last result before the verdict
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_ITEMS = 345;
	localparam int POOL_SIZE = 6;

	typedef struct {
		logic func;
		tag_t tag;
	} cache_cmd_t;

	typedef struct {
		logic     hit;
		way_out_t way;
	} cache_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic func = FUNC_LOOKUP;
	logic [TAG_IN_BITS-1:0] tag = '0;
	logic busy;
	logic done;
	logic hit;
	logic [WAY_OUT_BITS-1:0] way;

	// Commands waiting to be driven and outcomes waiting for their done strobe
	cache_cmd_t cmd_q[$];
	cache_outcome_t outcome_q[$];

	// Shadow copy of the set: tags, valid bits and LRU ages
	tag_t line_tag[WAYS];
	logic line_valid[WAYS];
	age_t line_age[WAYS];

	// Percent chance that the driver holds start low when it could present a command
	int idle_pct = 10;
	int mismatch_cnt = 0;
	int stall_cnt = 0;

	set_assoc_lru_cache_set_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.tag(tag),
		.done(done),
		.hit(hit),
		.way(way)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Age every way younger than the touched one, then make it the newest
	function automatic void touch_way(input int w);
		age_t r;
		r = line_age[w];
		for (int i = 0; i < WAYS; i++) begin
			if (line_age[i] > r)
				line_age[i] = line_age[i] - 1'b1;
		end
		line_age[w] = age_t'(WAYS);
	endfunction

	// Apply one transaction to the shadow set and return what done must show
	function automatic void cache_access(input logic fn, input tag_t t,
			output cache_outcome_t res);
		int found;
		int victim;
		found = -1;
		victim = 0;
		res.hit = 1'b0;
		res.way = '0;
		if (fn == FUNC_LOOKUP) begin
			// Lowest valid matching way wins; a miss leaves the set untouched
			for (int i = 0; i < WAYS; i++) begin
				if (found < 0 && line_valid[i] && line_tag[i] == t)
					found = i;
			end
			if (found >= 0) begin
				touch_way(found);
				res.hit = 1'b1;
				res.way = way_out_t'(found);
			end
		end else begin
			// Smallest age is replaced, lowest index on ties; no duplicate check
			for (int i = 1; i < WAYS; i++) begin
				if (line_age[i] < line_age[victim])
					victim = i;
			end
			line_tag[victim] = t;
			line_valid[victim] = 1'b1;
			touch_way(victim);
			res.way = way_out_t'(victim);
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		$display("[%0t] %s: got %0h, want %0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	function automatic void queue_cmd(input logic fn, input tag_t t);
		cache_cmd_t c;
		c.func = fn;
		c.tag = t;
		cmd_q = {cmd_q, c};
	endfunction

	// Driver: a transaction is taken at an edge where start is high and busy
	// low. Predict its outcome right there, then either present the next
	// command or idle. Hold the current command while busy keeps it off.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		cache_cmd_t c;
		cache_outcome_t res;
		logic taken;
		if (!arst_n) begin
			start <= 1'b0;
			func <= FUNC_LOOKUP;
			tag <= '0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				cache_access(func, tag_t'(tag), res);
				outcome_q = {outcome_q, res};
			end
			if (taken || !start) begin
				if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					c = cmd_q.pop_front();
					start <= 1'b1;
					func <= c.func;
					tag <= c.tag;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done strobe must match the oldest predicted outcome
	always @(posedge clk) begin : check_proc
		cache_outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				report_mismatch("done with no transaction outstanding", hit, 0);
			end else begin
				want = outcome_q.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", hit, want.hit);
				if (way !== want.way)
					report_mismatch("way", way, want.way);
			end
		end
	end

	// Watchdog: count cycles in which no transaction and no result moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("set_assoc_lru_cache_set_top: mismatch");
				$finish;
			end
		end
	end

	// Hold until every command is taken and every outcome has been checked
	task automatic wait_drained();
		while (cmd_q.size() != 0 || start || outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// Queue one phase of random traffic. Most tags come from a small pool so
	// lookups hit and fills collide with resident tags; some pool entries are
	// one bit away from another to catch partial compares. The rest are fully
	// random tags that almost always miss.
	task automatic queue_random_phase(input int n);
		tag_t pool[POOL_SIZE];
		tag_t t;
		int k;
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = $urandom;
		for (int n_i = 0; n_i < n; n_i++) begin
			if ($urandom_range(39) == 0) begin
				k = $urandom_range(POOL_SIZE - 1);
				if ($urandom_range(1))
					pool[k] = $urandom;
				else
					pool[k] = pool[$urandom_range(POOL_SIZE - 1)]
						^ (tag_t'(1) << $urandom_range(TAG_BITS - 1));
			end
			if ($urandom_range(99) < 85)
				t = pool[$urandom_range(POOL_SIZE - 1)];
			else
				t = $urandom;
			queue_cmd(($urandom_range(99) < 40) ? FUNC_FILL : FUNC_LOOKUP, t);
		end
	endtask

	initial begin
		for (int i = 0; i < WAYS; i++) begin
			line_tag[i] = '0;
			line_valid[i] = 1'b0;
			line_age[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: misses on an empty set, tag extremes, fills into ways of
		// equal age, a duplicate fill, lookups that see two copies of a tag,
		// and replacement once every way is in use.
		queue_cmd(FUNC_LOOKUP, '0);
		queue_cmd(FUNC_LOOKUP, '1);
		queue_cmd(FUNC_FILL, '1);
		queue_cmd(FUNC_FILL, '0);
		queue_cmd(FUNC_LOOKUP, '0);
		queue_cmd(FUNC_FILL, 32'hA5A5_A5A5);
		queue_cmd(FUNC_FILL, 32'h5A5A_5A5A);
		queue_cmd(FUNC_LOOKUP, '1);
		queue_cmd(FUNC_LOOKUP, 32'hA5A5_A5A5);
		queue_cmd(FUNC_LOOKUP, 32'hA5A5_A5A4);
		queue_cmd(FUNC_FILL, '0);
		queue_cmd(FUNC_LOOKUP, '0);
		queue_cmd(FUNC_LOOKUP, 32'h5A5A_5A5A);
		queue_cmd(FUNC_FILL, 32'h8000_0000);
		queue_cmd(FUNC_FILL, 32'h0000_0001);
		queue_cmd(FUNC_LOOKUP, 32'h8000_0000);
		queue_cmd(FUNC_LOOKUP, 32'h0000_0001);
		queue_cmd(FUNC_LOOKUP, '0);
		queue_cmd(FUNC_FILL, 32'h0000_0001);
		queue_cmd(FUNC_LOOKUP, 32'h0000_0001);
		queue_cmd(FUNC_LOOKUP, 32'h7FFF_FFFF);
		queue_cmd(FUNC_FILL, '1);
		queue_cmd(FUNC_LOOKUP, '1);

		// Random traffic: light sender gaps, then heavy gaps, then none
		queue_random_phase(PHASE_ITEMS);
		wait_drained();
		idle_pct = 78;
		queue_random_phase(PHASE_ITEMS);
		wait_drained();
		idle_pct = 0;
		queue_random_phase(PHASE_ITEMS);
		wait_drained();

		// Let any stray strobe show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("set_assoc_lru_cache_set_top: match");
		else
			$display("set_assoc_lru_cache_set_top: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/salc_pkg.sv
rtl/salc_age.sv
rtl/set_assoc_lru_cache_set_top.sv
sim/set_assoc_lru_cache_set_top_test.sv
